/* rtl/core/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the phase ramp rotator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define LPR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define LPR_ASSERT_SAME(label, clk, rst, ante, cons)
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/lpr_pkg.sv */
// Shared types, constants and the sine table generator of the phase ramp rotator.
package lpr_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_BITS      = 24;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int STEP_BITS       = 24;
  localparam int COEF_FRAC       = 23;
  localparam int CFG_INDEX_BITS  = 4;

  // Quarter-wave table: QUARTER_LEN + 1 entries, each in [0, 2^COEF_FRAC].
  localparam int QUARTER_LEN = 1 << TABLE_ADDR_BITS;
  localparam int COEF_BITS   = COEF_FRAC + 1;
  localparam int ROM_ADDR_W  = TABLE_ADDR_BITS + 1;
  localparam int PHASE_ADDR_W = TABLE_ADDR_BITS + 2;

  // Step alignment from 2^-STEP_BITS turns to 2^-PHASE_BITS turns.
  localparam int ALIGN_UP = (PHASE_BITS >= STEP_BITS) ? PHASE_BITS - STEP_BITS : 0;
  localparam int ALIGN_DN = (PHASE_BITS >= STEP_BITS) ? 0 : STEP_BITS - PHASE_BITS;
  localparam int ALIGN_W  = STEP_BITS + PHASE_BITS;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int SERIES_TERMS = 7;
  localparam logic [63:0] SeriesDiv [SERIES_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PRE_STEP  = CFG_INDEX_BITS'(0),
    REG_POST_STEP = CFG_INDEX_BITS'(1)
  } reg_index_t;

  typedef struct packed {
    logic                      en;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [STEP_BITS-1:0]      data;
  } cfg_write_t;

  typedef struct packed {
    logic mul_en;
    logic out_en;
  } pipe_ctrl_t;

  typedef logic [COEF_BITS-1:0] sine_tab_t [QUARTER_LEN+1];

  // Scales a configured step to the phase accumulator's resolution.
  function automatic logic [PHASE_BITS-1:0] align_step(input logic [STEP_BITS-1:0] s);
    logic [ALIGN_W-1:0] w;
    w = (ALIGN_W'(s) << ALIGN_UP) >> ALIGN_DN;
    return w[PHASE_BITS-1:0];
  endfunction

  // Builds the quarter-wave sine table with a truncated Q30 Taylor series.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
      term = x;
      sum  = signed'(x);
      for (int i = 0; i < SERIES_TERMS; i++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / SeriesDiv[i];
        if ((i % 2) == 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64) >>> 7;
      if (v > (64'sd1 <<< COEF_FRAC)) begin
        v = 64'sd1 <<< COEF_FRAC;
      end
      tab[k] = v[COEF_BITS-1:0];
    end
    return tab;
  endfunction

endpackage

/* rtl/core/lpr_sine_rom.sv */
// Quarter-wave sine ROM with two registered read ports.
module lpr_sine_rom (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lpr_pkg::ROM_ADDR_W-1:0]    addr_a,
  input  logic [lpr_pkg::ROM_ADDR_W-1:0]    addr_b,
  output logic [lpr_pkg::COEF_BITS-1:0]     data_a,
  output logic [lpr_pkg::COEF_BITS-1:0]     data_b
);
  import lpr_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Both ports read in the same cycle and hold while the stage is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= (addr_a <= ROM_ADDR_W'(QUARTER_LEN)) ? SINE_TAB[addr_a] : '0;
      data_b <= (addr_b <= ROM_ADDR_W'(QUARTER_LEN)) ? SINE_TAB[addr_b] : '0;
    end
  end

endmodule

/* rtl/core/lpr_phase_acc.sv */
// Step registers and the per-sample phase accumulator.
module lpr_phase_acc (
  input  logic                          clk,
  input  logic                          rst,
  input  lpr_pkg::cfg_write_t           cfg,
  input  logic                          advance,
  input  logic                          last,
  output logic [lpr_pkg::PHASE_BITS-1:0] phase
);
  import lpr_pkg::*;

  logic [STEP_BITS-1:0]  pre_step;
  logic [STEP_BITS-1:0]  post_step;
  logic [PHASE_BITS-1:0] phase_next;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_step  <= '0;
      post_step <= '0;
    end else if (cfg.en) begin
      if (cfg.index == REG_PRE_STEP) begin
        pre_step <= cfg.data;
      end else if (cfg.index == REG_POST_STEP) begin
        post_step <= cfg.data;
      end
    end
  end

  // The accumulator wraps modulo 2^PHASE_BITS and restarts after the last sample.
  always_comb begin
    if (last) begin
      phase_next = '0;
    end else begin
      phase_next = phase + align_step(pre_step) + align_step(post_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

endmodule

/* rtl/core/lpr_cmul.sv */
// Quadrant fold, complex multiply, rounding and saturation of one sample.
module lpr_cmul (
  input  logic                                  clk,
  input  lpr_pkg::pipe_ctrl_t                   ctrl,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] x,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] y,
  input  lpr_pkg::quad_t                        quad,
  input  logic [lpr_pkg::COEF_BITS-1:0]         sin_k,
  input  logic [lpr_pkg::COEF_BITS-1:0]         sin_nk,
  input  logic                                  last,
  output logic signed [lpr_pkg::SAMPLE_BITS-1:0] out_real,
  output logic signed [lpr_pkg::SAMPLE_BITS-1:0] out_imag,
  output logic                                  out_last
);
  import lpr_pkg::*;

  localparam int COS_W  = COEF_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + COS_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - 1;

  logic signed [COS_W-1:0]  pos_k;
  logic signed [COS_W-1:0]  pos_nk;
  logic signed [COS_W-1:0]  cos_v;
  logic signed [COS_W-1:0]  sin_v;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_ys;
  logic signed [PROD_W-1:0] p_yc;
  logic signed [PROD_W-1:0] p_xs;
  logic                     last_m;
  logic signed [SUM_W-1:0]  sum_re;
  logic signed [SUM_W-1:0]  sum_im;
  logic signed [SUM_W-1:0]  rnd_re;
  logic signed [SUM_W-1:0]  rnd_im;
  logic signed [SUM_W-1:0]  sat_re;
  logic signed [SUM_W-1:0]  sat_im;

  // Unfold the quarter-wave entries into cos and sin of the full turn.
  always_comb begin
    pos_k  = signed'(COS_W'(sin_k));
    pos_nk = signed'(COS_W'(sin_nk));
    unique case (quad)
      QUAD_I: begin
        sin_v = pos_k;
        cos_v = pos_nk;
      end
      QUAD_II: begin
        sin_v = pos_nk;
        cos_v = -pos_k;
      end
      QUAD_III: begin
        sin_v = -pos_k;
        cos_v = -pos_nk;
      end
      QUAD_IV: begin
        sin_v = -pos_nk;
        cos_v = pos_k;
      end
      default: begin
        sin_v = '0;
        cos_v = '0;
      end
    endcase
  end

  // Four partial products, registered before they are combined.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_xc   <= PROD_W'(x) * PROD_W'(cos_v);
      p_ys   <= PROD_W'(y) * PROD_W'(sin_v);
      p_yc   <= PROD_W'(y) * PROD_W'(cos_v);
      p_xs   <= PROD_W'(x) * PROD_W'(sin_v);
      last_m <= last;
    end
  end

  // Combine, round half up and clip to the sample range.
  always_comb begin
    sum_re = SUM_W'(p_xc) + SUM_W'(p_ys);
    sum_im = SUM_W'(p_yc) - SUM_W'(p_xs);
    rnd_re = (sum_re + ROUND_HALF) >>> COEF_FRAC;
    rnd_im = (sum_im + ROUND_HALF) >>> COEF_FRAC;
    if (rnd_re > SAT_MAX) begin
      sat_re = SAT_MAX;
    end else if (rnd_re < SAT_MIN) begin
      sat_re = SAT_MIN;
    end else begin
      sat_re = rnd_re;
    end
    if (rnd_im > SAT_MAX) begin
      sat_im = SAT_MAX;
    end else if (rnd_im < SAT_MIN) begin
      sat_im = SAT_MIN;
    end else begin
      sat_im = rnd_im;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      out_real <= sat_re[SAMPLE_BITS-1:0];
      out_imag <= sat_im[SAMPLE_BITS-1:0];
      out_last <= last_m;
    end
  end

endmodule

/* rtl/core/linear_phase_ramp_rotator.sv */
// Top level of the linear phase ramp rotator: handshakes, input stage and assertions.
//
// Usage:
// - Input channel in_valid/in_ready carries one complex sample word per
//   transfer (in_real, in_imag, in_last). Output channel out_valid/out_ready
//   returns one rotated word per input word, in order.
// - Configuration channel cfg_valid/cfg_ready writes pre_step (index 0) or
//   post_step (index 1); cfg_ready is always high. Other indexes are ignored.
//   Write only while no word is in flight.
// - Each sample is rotated by the phase accumulator value it arrives with;
//   the accumulator then adds both steps, or restarts at zero after a word
//   marked last.
// - out_valid rises once the word has passed the sine ROM read, multiplier
//   and output registers. Throughput is one word per cycle while the output
//   is not stalled by out_ready.
// - Each stage has its own valid bit, so bubbles are squeezed out and the
//   block keeps taking words while the output word waits; in_ready drops only
//   when all three stages are full and out_ready is low.
// - Synchronous reset clears the step registers, the accumulator and all
//   valid bits; the first sample after reset uses phase zero.
`include "assert_macros.svh"

module linear_phase_ramp_rotator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lpr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [lpr_pkg::STEP_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] in_real,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] in_imag,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lpr_pkg::SAMPLE_BITS-1:0] out_real,
  output logic signed [lpr_pkg::SAMPLE_BITS-1:0] out_imag,
  output logic                                  out_last
);
  import lpr_pkg::*;

  cfg_write_t                      cfg;
  pipe_ctrl_t                      ctrl;
  logic [PHASE_BITS-1:0]           phase;
  logic [PHASE_BITS+PHASE_ADDR_W-1:0] phase_pad;
  logic [PHASE_ADDR_W-1:0]         phase_addr;
  logic [TABLE_ADDR_BITS-1:0]      tab_k;
  logic [ROM_ADDR_W-1:0]           rom_addr_a;
  logic [ROM_ADDR_W-1:0]           rom_addr_b;
  logic [COEF_BITS-1:0]            sin_k;
  logic [COEF_BITS-1:0]            sin_nk;
  logic                            in_fire;
  logic                            ready_1;
  logic                            ready_2;
  logic                            ready_3;
  logic                            valid_1;
  logic                            valid_2;
  logic signed [SAMPLE_BITS-1:0]   x_1;
  logic signed [SAMPLE_BITS-1:0]   y_1;
  logic                            last_1;
  quad_t                           quad_1;

  // Configuration port takes a write every cycle.
  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Stage ready chain: a stage can load when it is empty or its word moves on.
  assign ready_3  = !out_valid || out_ready;
  assign ready_2  = !valid_2 || ready_3;
  assign ready_1  = !valid_1 || ready_2;
  assign in_ready = ready_1;
  assign in_fire  = in_valid && ready_1;

  assign ctrl.mul_en = ready_2;
  assign ctrl.out_en = ready_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_1   <= 1'b0;
      valid_2   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_1) begin
        valid_1 <= in_valid;
      end
      if (ready_2) begin
        valid_2 <= valid_1;
      end
      if (ready_3) begin
        out_valid <= valid_2;
      end
    end
  end

  lpr_phase_acc u_phase_acc (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (in_fire),
    .last    (in_last),
    .phase   (phase)
  );

  // Table address from the top bits of the phase, zero-padded below if short.
  always_comb begin
    phase_pad  = {phase, PHASE_ADDR_W'(0)};
    phase_addr = phase_pad[PHASE_BITS+PHASE_ADDR_W-1 -: PHASE_ADDR_W];
    tab_k      = phase_addr[TABLE_ADDR_BITS-1:0];
    rom_addr_a = ROM_ADDR_W'(tab_k);
    rom_addr_b = ROM_ADDR_W'(QUARTER_LEN) - ROM_ADDR_W'(tab_k);
  end

  lpr_sine_rom u_sine_rom (
    .clk    (clk),
    .en     (ready_1),
    .addr_a (rom_addr_a),
    .addr_b (rom_addr_b),
    .data_a (sin_k),
    .data_b (sin_nk)
  );

  // Input stage, aligned with the ROM read register.
  always_ff @(posedge clk) begin
    if (ready_1) begin
      x_1    <= in_real;
      y_1    <= in_imag;
      last_1 <= in_last;
      quad_1 <= quad_t'(phase_addr[PHASE_ADDR_W-1 -: 2]);
    end
  end

  lpr_cmul u_cmul (
    .clk      (clk),
    .ctrl     (ctrl),
    .x        (x_1),
    .y        (y_1),
    .quad     (quad_1),
    .sin_k    (sin_k),
    .sin_nk   (sin_nk),
    .last     (last_1),
    .out_real (out_real),
    .out_imag (out_imag),
    .out_last (out_last)
  );

  // The phase restarts at zero right after a word marked last is taken.
  `LPR_ASSERT_NEXT(a_last_clears_phase, clk, rst, in_fire && in_last, phase == '0)
  // Input is held back only while the first stage holds a word.
  `LPR_ASSERT_SAME(a_stall_needs_word, clk, rst, !in_ready, valid_1)
  // A full pipeline facing a stalled receiver must refuse new words.
  `LPR_ASSERT_SAME(a_full_blocks_input, clk, rst, valid_1 && !ready_2, !in_ready)

endmodule

/* verif/phase_rotation_checker.sv */
// Checker for the phase ramp rotator: predicts each rotated word and compares the output stream.
module phase_rotation_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [lpr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [lpr_pkg::STEP_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] in_real,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] in_imag,
  input  logic                                   in_last,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] out_real,
  input  logic signed [lpr_pkg::SAMPLE_BITS-1:0] out_imag,
  input  logic                                   out_last,
  output int                                     errors,
  output int                                     pending
);
  import lpr_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          last;
  } rotated_word_t;

  localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (SAMPLE_BITS - 1));

  logic [COEF_BITS-1:0]  quarter_sine [QUARTER_LEN+1];
  logic [STEP_BITS-1:0]  pre_step_q;
  logic [STEP_BITS-1:0]  post_step_q;
  logic [PHASE_BITS-1:0] phase_acc;
  rotated_word_t         rotated_q [$];

  // Quarter-wave sine table: Q30 odd-power series up to x^15, rounded to Q23.
  initial begin
    logic [63:0]        ang;
    logic [63:0]        pw;
    logic signed [63:0] acc;
    logic signed [63:0] rnd;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      ang = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
      pw  = ang;
      acc = signed'(ang);
      for (int n = 3; n <= 15; n += 2) begin
        pw = (((pw * ang) >> 30) * ang) >> 30;
        pw = pw / 64'((n - 1) * n);
        if ((((n - 1) / 2) % 2) == 1) begin
          acc = acc - signed'(pw);
        end else begin
          acc = acc + signed'(pw);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      rnd = (acc + 64) >>> 7;
      if (rnd > (64'sd1 <<< COEF_FRAC)) begin
        rnd = 64'sd1 <<< COEF_FRAC;
      end
      quarter_sine[k] = rnd[COEF_BITS-1:0];
    end
  end

  // Rounds half up at the coefficient binary point and clips to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] round_clip(input longint prod);
    longint r;
    r = (prod + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end
    if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  // Converts a step in 2^-24 turns to accumulator units.
  function automatic logic [PHASE_BITS-1:0] to_phase_units(input logic [STEP_BITS-1:0] s);
    if (PHASE_BITS >= STEP_BITS) begin
      return PHASE_BITS'(s) << (PHASE_BITS - STEP_BITS);
    end
    return PHASE_BITS'(s >> (STEP_BITS - PHASE_BITS));
  endfunction

  // Multiplies one sample by cos - j*sin of the given phase.
  function automatic rotated_word_t rotate_word(input logic signed [SAMPLE_BITS-1:0] re,
                                                input logic signed [SAMPLE_BITS-1:0] im,
                                                input logic                          last,
                                                input logic [PHASE_BITS-1:0]         ph);
    logic [PHASE_ADDR_W-1:0] addr;
    quad_t                   quad;
    int                      idx;
    longint                  sin_v;
    longint                  cos_v;
    longint                  xr;
    longint                  xi;
    rotated_word_t           w;
    addr = ph[PHASE_BITS-1 -: PHASE_ADDR_W];
    quad = quad_t'(addr[PHASE_ADDR_W-1 -: 2]);
    idx  = int'(addr[TABLE_ADDR_BITS-1:0]);
    case (quad)
      QUAD_I: begin
        sin_v = longint'(quarter_sine[idx]);
        cos_v = longint'(quarter_sine[QUARTER_LEN-idx]);
      end
      QUAD_II: begin
        sin_v = longint'(quarter_sine[QUARTER_LEN-idx]);
        cos_v = -longint'(quarter_sine[idx]);
      end
      QUAD_III: begin
        sin_v = -longint'(quarter_sine[idx]);
        cos_v = -longint'(quarter_sine[QUARTER_LEN-idx]);
      end
      default: begin
        sin_v = -longint'(quarter_sine[QUARTER_LEN-idx]);
        cos_v = longint'(quarter_sine[idx]);
      end
    endcase
    xr     = longint'(re);
    xi     = longint'(im);
    w.re   = round_clip(xr * cos_v + xi * sin_v);
    w.im   = round_clip(xi * cos_v - xr * sin_v);
    w.last = last;
    return w;
  endfunction

  // Track register writes and input words, then check each output word in order.
  always @(posedge clk) begin
    rotated_word_t head;
    if (rst) begin
      pre_step_q  = '0;
      post_step_q = '0;
      phase_acc   = '0;
      rotated_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRE_STEP:  pre_step_q  = cfg_data;
          REG_POST_STEP: post_step_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        rotated_q.push_back(rotate_word(in_real, in_imag, in_last, phase_acc));
        if (in_last) begin
          phase_acc = '0;
        end else begin
          phase_acc = phase_acc + to_phase_units(pre_step_q) + to_phase_units(post_step_q);
        end
      end
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $error("output word with no expectation pending");
          errors++;
        end else begin
          head = rotated_q.pop_front();
          if (out_real !== head.re) begin
            $error("out_real mismatch: expected %0d, got %0d", head.re, out_real);
            errors++;
          end
          if (out_imag !== head.im) begin
            $error("out_imag mismatch: expected %0d, got %0d", head.im, out_imag);
            errors++;
          end
          if (out_last !== head.last) begin
            $error("out_last mismatch: expected %0d, got %0d", head.last, out_last);
            errors++;
          end
        end
      end
    end
    pending = rotated_q.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the phase ramp rotator: clock, reset, stimulus, output stalls and verdict.
module tb_top;
  import lpr_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int RANDOM_WORDS = 700;
  localparam int HOLD_CYCLES  = 300;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [STEP_BITS-1:0]          cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_real;
  logic signed [SAMPLE_BITS-1:0] in_imag;
  logic                          in_last;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] out_real;
  logic signed [SAMPLE_BITS-1:0] out_imag;
  logic                          out_last;

  int mismatch_count;
  int words_in_flight;
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  bit hold_req   = 1'b0;

  linear_phase_ramp_rotator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_real   (in_real),
    .in_imag   (in_imag),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_real  (out_real),
    .out_imag  (out_imag),
    .out_last  (out_last)
  );

  phase_rotation_checker u_check (
    .*,
    .errors  (mismatch_count),
    .pending (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one sample word in bursts with random gaps while gaps_on is set; valid stays high across a burst.
  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] re,
                           input logic signed [SAMPLE_BITS-1:0] im,
                           input logic                          last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gaps_on && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_real  <= re;
    in_imag  <= im;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering words and waits until every predicted word has come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_in_flight != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Writes one register; the caller drops cfg_valid after the last write.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [STEP_BITS-1:0]      val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Loads both steps while idle, optionally with a write to an unused index.
  task automatic program_steps(input logic [STEP_BITS-1:0] pre, input logic [STEP_BITS-1:0] post,
                               input bit with_unused);
    drain_pipeline();
    write_reg(REG_PRE_STEP, pre);
    if (with_unused) begin
      write_reg(CFG_INDEX_BITS'($urandom_range(2, (1 << CFG_INDEX_BITS) - 1)),
                STEP_BITS'($urandom));
    end
    write_reg(REG_POST_STEP, post);
    cfg_valid <= 1'b0;
  endtask

  // Sample values weighted toward full scale and values near zero.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return FULL_POS;
      1: return FULL_NEG;
      2: begin
        v = int'($urandom_range(0, 16)) - 8;
        return v[SAMPLE_BITS-1:0];
      end
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Step values with the extremes, a quarter turn and slow ramps mixed in.
  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return STEP_BITS'(1);
      3: return STEP_BITS'(1) << (STEP_BITS - 2);
      4: return STEP_BITS'($urandom_range(1, 4096));
      default: return STEP_BITS'($urandom);
    endcase
  endfunction

  // Output stalls: random patterns in segments, plus a long hold-off on request.
  initial begin
    int mode;
    int span;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int n = 0; n < span && !hold_req; n++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 4) != 0);
          default: out_ready <= ((n % 4) != 3);
        endcase
        @(posedge clk);
      end
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
    end
  end

  // Stimulus: directed corners first, then random lines under random step settings.
  initial begin
    int sent;
    int phase_no;
    int line_len;
    bit drop_last;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_real   <= '0;
    in_imag   <= '0;
    in_last   <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero steps after reset: words must pass through unchanged.
    send_word(FULL_POS, FULL_NEG, 1'b0);
    send_word(FULL_NEG, FULL_POS, 1'b0);
    send_word('0, '0, 1'b0);
    send_word(SAMPLE_BITS'(-1), SAMPLE_BITS'(1), 1'b0);
    send_word(FULL_NEG, FULL_NEG, 1'b1);

    // An eighth of a turn per sample walks through all four quadrants and saturates.
    program_steps(STEP_BITS'(1) << (STEP_BITS - 4), STEP_BITS'(1) << (STEP_BITS - 4), 1'b0);
    for (int k = 0; k <= 8; k++) begin
      send_word((k % 2 == 1) ? FULL_POS : FULL_NEG, FULL_NEG, k == 8);
    end

    // Largest steps: the sum of both wraps around the accumulator.
    program_steps('1, '1, 1'b1);
    send_word(FULL_POS, FULL_POS, 1'b0);
    send_word(FULL_NEG, FULL_POS, 1'b0);
    send_word(pick_sample(), pick_sample(), 1'b0);
    send_word(FULL_POS, FULL_NEG, 1'b1);

    // Smallest nonzero step, with a write to an unused index that must be ignored.
    program_steps('0, STEP_BITS'(1), 1'b1);
    send_word(FULL_POS, FULL_POS, 1'b0);
    send_word(FULL_NEG, FULL_NEG, 1'b0);
    send_word(FULL_POS, FULL_NEG, 1'b1);

    // Random lines; some lines lose their last marker so the phase carries over.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_WORDS) begin
      program_steps(pick_step(), pick_step(), $urandom_range(0, 3) == 0);
      if (phase_no == 1 || phase_no == 5) begin
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        for (int i = 0; i < 40; i++) begin
          send_word(pick_sample(), pick_sample(), i == 39);
        end
        gaps_on = 1'b1;
        sent += 40;
      end
      repeat ($urandom_range(2, 6)) begin
        line_len  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
        drop_last = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < line_len; i++) begin
          if ($urandom_range(0, 99) == 0) begin
            drain_pipeline();
          end
          send_word(pick_sample(), pick_sample(), (i == line_len - 1) && !drop_last);
        end
        sent += line_len;
      end
      phase_no++;
    end

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
